### design/assert_macros.svh
// Assertion macros used by the RTL top level.
// No dependencies; expects clk and rst_n in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWRMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWRMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/swrms_pkg.sv
// Shared constants, register codes and interface types of the RMS power meter.
// No dependencies.
package swrms_pkg;

  // Ring geometry
  localparam int WINDOW_MAX = 1024;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int SIZE_W     = PTR_W + 1;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 41;
  localparam int RMS_W    = 24;
  localparam int WIN_W    = 16;

  // Divide and root unit: two quotient bits or one root bit per cycle
  localparam int QUO_W      = 48;
  localparam int UNIT_STEPS = 24;
  localparam int CNT_W      = $clog2(UNIT_STEPS);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SLIDE = 1'd1;

  localparam logic [SIZE_W-1:0] SIZE_RESET  = 11'd256;
  localparam logic [SIZE_W-1:0] SLIDE_RESET = 11'd256;

  // Requests to and status from the divide and root unit
  typedef struct packed {
    logic start;
    logic take;
  } rms_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rms_stat_t;

endpackage

### design/swrms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swrms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/swrms_rms_unit.sv
// Iterative divide and square root: floor(sqrt(sum * 65536 / size)).
// Depends on swrms_pkg.
module swrms_rms_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swrms_pkg::rms_req_t         req,
  input  logic [swrms_pkg::SUM_W-1:0] sum,
  input  logic [swrms_pkg::SIZE_W-1:0] size,
  output swrms_pkg::rms_stat_t        stat,
  output logic [swrms_pkg::RMS_W-1:0] root
);
  import swrms_pkg::*;

  typedef enum logic [1:0] {U_IDLE, U_DIV, U_ROOT, U_DONE} ustate_t;

  ustate_t           st_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] rem_r;     // division remainder, always below size
  logic [QUO_W-1:0]  dq_r;      // dividend bits in, quotient bits out
  logic [RMS_W+1:0]  srem_r;    // root remainder
  logic [RMS_W-1:0]  root_r;

  logic [SIZE_W:0]   ra, rb;
  logic              qa, qb;
  logic [SIZE_W-1:0] ra_left, rem_nxt;
  logic [RMS_W+3:0]  st_part, st_trial;
  logic              st_ge;
  logic [RMS_W+1:0]  srem_nxt;

  // Two restoring division steps per cycle
  always_comb begin
    ra      = {rem_r, dq_r[QUO_W-1]};
    qa      = (ra >= {1'b0, size_r});
    ra_left = qa ? SIZE_W'(ra - {1'b0, size_r}) : SIZE_W'(ra);
    rb      = {ra_left, dq_r[QUO_W-2]};
    qb      = (rb >= {1'b0, size_r});
    rem_nxt = qb ? SIZE_W'(rb - {1'b0, size_r}) : SIZE_W'(rb);
  end

  // One root bit per cycle, consuming the quotient two bits at a time
  always_comb begin
    st_part  = {srem_r, dq_r[QUO_W-1:QUO_W-2]};
    st_trial = {2'b00, root_r, 2'b01};
    st_ge    = (st_part >= st_trial);
    srem_nxt = st_ge ? (RMS_W+2)'(st_part - st_trial) : (RMS_W+2)'(st_part);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= U_IDLE;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        U_IDLE: begin
          if (req.start) begin
            // sum >> 32 is below size, so the first quotient bits are zero
            rem_r  <= SIZE_W'(sum[SUM_W-1:32]);
            dq_r   <= {sum[31:0], 16'h0000};
            size_r <= size;
            cnt_r  <= '0;
            st_r   <= U_DIV;
          end
        end
        U_DIV: begin
          rem_r <= rem_nxt;
          dq_r  <= {dq_r[QUO_W-3:0], qa, qb};
          if (cnt_r == CNT_W'(UNIT_STEPS - 1)) begin
            cnt_r  <= '0;
            srem_r <= '0;
            root_r <= '0;
            st_r   <= U_ROOT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        U_ROOT: begin
          srem_r <= srem_nxt;
          root_r <= {root_r[RMS_W-2:0], st_ge};
          dq_r   <= {dq_r[QUO_W-3:0], 2'b00};
          if (cnt_r == CNT_W'(UNIT_STEPS - 1)) begin
            st_r <= U_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        U_DONE: begin
          if (req.take) begin
            st_r <= U_IDLE;
          end
        end
        default: st_r <= U_IDLE;
      endcase
    end
  end

  assign stat.busy = (st_r != U_IDLE);
  assign stat.done = (st_r == U_DONE);
  assign root      = root_r;

endmodule

### design/sliding_window_rms_power_top.sv
// Sliding-window RMS power meter: squares of the latest samples sit in a
// 1024-entry ring RAM beside a 41-bit running sum; each closing window yields
// floor(sqrt(sum*65536/size)) in unsigned Q.8 with its window number.
// An item that closes no window passes through accept with ring read, then
// sum update and ring write-back. An item that closes a window then goes
// through radix-4 division, the bit-per-cycle square root and the handover
// of the result into the output register. The ring needs no clearing pass
// after reset; only entries written in the current record are ever used.
// No new item is taken while a result still waits.
// Depends on swrms_pkg, swrms_ram, swrms_rms_unit and assert_macros.svh.
`include "assert_macros.svh"

module sliding_window_rms_power_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [swrms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swrms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [swrms_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                              in_last_of_record,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [swrms_pkg::RMS_W-1:0]       out_rms_q8,
  output logic [swrms_pkg::WIN_W-1:0]       out_window_number
);
  import swrms_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_WAIT} state_t;

  state_t            st_r;
  logic [SIZE_W-1:0] size_cfg_r, slide_cfg_r;
  logic [SUM_W-1:0]  sum_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [SIZE_W-1:0] fill_r, cd_r;
  logic [WIN_W-1:0]  wc_r, win_num_r;
  logic [SQ_W-1:0]   sq_r;
  logic              last_r;
  logic              out_valid_r;
  logic [RMS_W-1:0]  out_rms_r;
  logic [WIN_W-1:0]  out_win_r;

  logic [SIZE_W-1:0] size_eff, slide_eff;
  logic              in_acc;
  logic signed [SAMPLE_W:0] sx;
  logic [SAMPLE_W:0] mag;
  logic [2*SAMPLE_W+1:0] prod;
  logic [PTR_W-1:0]  old_addr;
  logic [SQ_W-1:0]   ring_rd;
  logic              ring_we;

  logic              full_before, emit;
  logic [SUM_W-1:0]  sum_nxt;
  logic [SIZE_W-1:0] fill_nxt, cd_nxt, fill_inc, cd_dec;

  logic              out_free, out_load;
  rms_req_t          rms_req;
  rms_stat_t         rms_stat;
  logic [RMS_W-1:0]  rms_root;

  // Effective register values: zero acts as one, size clamps to the ring
  always_comb begin
    priority if (size_cfg_r == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_cfg_r > SIZE_W'(WINDOW_MAX)) begin
      size_eff = SIZE_W'(WINDOW_MAX);
    end else begin
      size_eff = size_cfg_r;
    end
    slide_eff = (slide_cfg_r == '0) ? SIZE_W'(1) : slide_cfg_r;
  end

  // Intake: square the sample and fetch the square leaving the window
  assign in_stall = (st_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign sx       = {in_sample[SAMPLE_W-1], in_sample};
  assign mag      = sx[SAMPLE_W] ? (SAMPLE_W+1)'(-sx) : (SAMPLE_W+1)'(sx);
  assign prod     = {{(SAMPLE_W+1){1'b0}}, mag} * {{(SAMPLE_W+1){1'b0}}, mag};
  assign old_addr = ptr_r - size_eff[PTR_W-1:0];
  assign ring_we  = (st_r == S_UPD);

  swrms_ram #(
    .WIDTH (SQ_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr_r),
    .wdata (sq_r),
    .re    (in_acc),
    .raddr (old_addr),
    .rdata (ring_rd)
  );

  // Update: running sum and window bookkeeping
  always_comb begin
    full_before = (fill_r >= size_eff);
    sum_nxt     = sum_r + SUM_W'(sq_r) - (full_before ? SUM_W'(ring_rd) : '0);
    fill_inc    = fill_r + 1'b1;
    cd_dec      = (cd_r != '0) ? cd_r - 1'b1 : '0;
    fill_nxt    = fill_r;
    cd_nxt      = cd_r;
    emit        = 1'b0;
    if (!full_before) begin
      fill_nxt = fill_inc;
      if (fill_inc >= size_eff) begin
        emit   = 1'b1;
        cd_nxt = slide_eff;
      end
    end else if (cd_dec == '0) begin
      emit   = 1'b1;
      cd_nxt = slide_eff;
    end else begin
      cd_nxt = cd_dec;
    end
  end

  // Result handover into the output register
  assign out_free      = !out_valid_r || !out_stall;
  assign out_load      = (st_r == S_WAIT) && rms_stat.done && out_free;
  assign rms_req.start = (st_r == S_UPD) && emit;
  assign rms_req.take  = out_load;

  swrms_rms_unit u_rms (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rms_req),
    .sum   (sum_nxt),
    .size  (size_eff),
    .stat  (rms_stat),
    .root  (rms_root)
  );

  // Control, record state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      size_cfg_r  <= SIZE_RESET;
      slide_cfg_r <= SLIDE_RESET;
      sum_r       <= '0;
      ptr_r       <= '0;
      fill_r      <= '0;
      cd_r        <= '0;
      wc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            sq_r   <= prod[SQ_W-1:0];
            last_r <= in_last_of_record;
            st_r   <= S_UPD;
          end
        end
        S_UPD: begin
          sum_r  <= sum_nxt;
          ptr_r  <= ptr_r + 1'b1;
          fill_r <= fill_nxt;
          cd_r   <= cd_nxt;
          if (emit) begin
            win_num_r <= wc_r;
            wc_r      <= wc_r + 1'b1;
            st_r      <= S_WAIT;
          end else begin
            st_r <= S_IDLE;
          end
          // End of record: clear after any emission
          if (last_r) begin
            sum_r  <= '0;
            ptr_r  <= '0;
            fill_r <= '0;
            cd_r   <= '0;
            wc_r   <= '0;
          end
        end
        S_WAIT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_rms_r   <= rms_root;
            out_win_r   <= win_num_r;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
      // Register writes start a new record
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_SIZE:  size_cfg_r  <= cfg_data;
          REG_WINDOW_SLIDE: slide_cfg_r <= cfg_data;
          default: ;
        endcase
        sum_r  <= '0;
        ptr_r  <= '0;
        fill_r <= '0;
        cd_r   <= '0;
        wc_r   <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rms_q8        = out_rms_r;
  assign out_window_number = out_win_r;

  // Checks
  `SWRMS_ASSERT_SAME(a_fill_bounded, 1'b1, fill_r <= size_eff, "fill count above window size")
  `SWRMS_ASSERT_SAME(a_start_idle, rms_req.start, !rms_stat.busy, "root unit started while busy")
  `SWRMS_ASSERT_NEXT(a_accept_busy, in_acc, in_stall, "item taken while previous in flight")
  `SWRMS_ASSERT_SAME(a_wait_unit, st_r == S_WAIT, rms_stat.busy, "waiting with root unit idle")

endmodule

### test/testbench.sv
// Self-checking testbench for sliding_window_rms_power_top: drives sample items,
// predicts each window's Q.8 RMS and number, and checks every result item.
// Depends on swrms_pkg and the RTL under design/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import swrms_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_item_t;

  typedef struct packed {
    logic [RMS_W-1:0] rms_q8;
    logic [WIN_W-1:0] window_number;
  } rms_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_WINDOW_SIZE;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_last_of_record = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [RMS_W-1:0]           out_rms_q8;
  logic [WIN_W-1:0]           out_window_number;

  sample_item_t sample_queue[$];
  rms_result_t  expected_rms[$];
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  int           quiet_cycles = 0;

  // Predictor state: register copies and the current record
  logic [SIZE_W-1:0] size_setting = SIZE_RESET;
  logic [SIZE_W-1:0] slide_setting = SLIDE_RESET;
  logic [SQ_W-1:0]   square_history [WINDOW_MAX];
  logic [SUM_W-1:0]  window_energy = '0;
  int                write_slot = 0;
  int                record_fill = 0;
  int                samples_to_close = 0;
  logic [WIN_W-1:0]  next_window = '0;

  sliding_window_rms_power_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_last_of_record(in_last_of_record),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rms_q8       (out_rms_q8),
    .out_window_number(out_window_number)
  );

  always #2 clk = ~clk;

  function automatic int active_size();
    if (size_setting == 0) return 1;
    if (size_setting > WINDOW_MAX) return WINDOW_MAX;
    return size_setting;
  endfunction

  function automatic int active_slide();
    return (slide_setting == 0) ? 1 : slide_setting;
  endfunction

  function automatic void clear_record();
    window_energy    = '0;
    write_slot       = 0;
    record_fill      = 0;
    samples_to_close = 0;
    next_window      = '0;
  endfunction

  // Floored square root, one result bit per pass
  function automatic logic [31:0] floor_sqrt(logic [63:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= x) root = trial;
    end
    return root;
  endfunction

  // Update the window energy for one accepted sample and queue any closing window
  function automatic void predict_window(logic signed [SAMPLE_W-1:0] sample, logic last);
    logic [SAMPLE_W:0] mag;
    logic [SQ_W-1:0]   square;
    logic [63:0]       mean_q16;
    rms_result_t       res;
    int                size;
    bit                was_full;
    bit                closes;
    size     = active_size();
    mag      = sample[SAMPLE_W-1] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
    square   = mag * mag;
    was_full = record_fill >= size;
    closes   = 1'b0;
    if (was_full)
      window_energy = window_energy
                      - square_history[(write_slot + WINDOW_MAX - size) % WINDOW_MAX];
    window_energy = window_energy + square;
    square_history[write_slot] = square;
    write_slot = (write_slot + 1) % WINDOW_MAX;
    if (!was_full) begin
      record_fill++;
      if (record_fill >= size) begin
        closes = 1'b1;
        samples_to_close = active_slide();
      end
    end else begin
      if (samples_to_close > 0) samples_to_close--;
      if (samples_to_close == 0) begin
        closes = 1'b1;
        samples_to_close = active_slide();
      end
    end
    if (closes) begin
      mean_q16          = (64'(window_energy) << 16) / 64'(size);
      res.rms_q8        = RMS_W'(floor_sqrt(mean_q16));
      res.window_number = next_window;
      next_window       = next_window + 1'b1;
      expected_rms.push_back(res);
    end
    if (last) clear_record();
  endfunction

  // Sample driver
  always @(posedge clk) begin : drive_samples
    sample_item_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_window(in_sample, in_last_of_record);
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item = sample_queue.pop_front();
          in_valid          <= 1'b1;
          in_sample         <= item.sample;
          in_last_of_record <= item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin : check_results
    rms_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rms.size() == 0) begin
        $error("unexpected result: rms_q8 %0d window_number %0d",
               out_rms_q8, out_window_number);
        error_count++;
      end else begin
        want = expected_rms.pop_front();
        if (out_rms_q8 !== want.rms_q8) begin
          $error("rms_q8: expected %0d, got %0d", want.rms_q8, out_rms_q8);
          error_count++;
        end
        if (out_window_number !== want.window_number) begin
          $error("window_number: expected %0d, got %0d",
                 want.window_number, out_window_number);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_for_drain();
    while (sample_queue.size() != 0 || in_valid || expected_rms.size() != 0)
      @(posedge clk);
    // items that close no window may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_SIZE) size_setting = SIZE_W'(value);
    else slide_setting = SIZE_W'(value);
    clear_record();
  endtask

  task automatic configure(int size, int slide);
    wait_for_drain();
    write_register(REG_WINDOW_SIZE, size);
    write_register(REG_WINDOW_SLIDE, slide);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 47; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 47; end
      default: begin send_idle_pct = 20; stall_pct = 20; end
    endcase
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return -16'sd1;
      4: return SAMPLE_W'(int'($urandom_range(16)) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_sample(logic signed [SAMPLE_W-1:0] sample, logic last);
    sample_item_t item;
    item.sample = sample;
    item.last   = last;
    sample_queue.push_back(item);
  endtask

  // A run of random samples, closed by an end-of-record marker when asked
  task automatic push_record(int len, bit terminate);
    for (int i = 0; i < len; i++)
      push_sample(pick_sample(), terminate && (i == len - 1));
  endtask

  // Mostly whole records of one window or more, some short or unterminated
  task automatic random_phase(int size, int slide, int n_items);
    int eff_size;
    int eff_slide;
    int hi;
    int len;
    int pushed;
    int pick;
    eff_size  = (size == 0) ? 1 : (size > WINDOW_MAX ? WINDOW_MAX : size);
    eff_slide = (slide == 0) ? 1 : slide;
    pushed    = 0;
    configure(size, slide);
    while (pushed < n_items) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        hi = eff_size + 3 * eff_slide;
        if (hi > 120) hi = 120;
        len = $urandom_range(eff_size, hi);
        push_record(len, 1'b1);
      end else if (pick < 8) begin
        len = $urandom_range(1, eff_size);
        push_record(len, 1'b1);
      end else begin
        len = $urandom_range(1, 40);
        push_record(len, pick == 8);
      end
      pushed += len;
    end
  endtask

  initial begin : stimulus
    int sizes  [12] = '{1, 2, 3, 4, 8, 5, 0, 16, 1, 7, 1024, 2047};
    int slides [12] = '{1, 1, 2, 9, 8, 3, 0, 4, 2047, 1, 1024, 1};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Settings straight out of reset: one window of 256
    set_idling(3);
    push_record(260, 1'b1);

    // Zero size and slide act as one: every sample closes a window
    configure(0, 0);
    set_idling(0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample('0, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh8000, 1'b1);

    // Slide wider than size, a record too short for any window, floored mean
    configure(3, 5);
    set_idling(2);
    push_sample(16'sd100, 1'b0);
    push_sample(-16'sd100, 1'b1);
    push_record(9, 1'b1);

    // Window closing on the end-of-record sample
    configure(2, 2);
    set_idling(1);
    push_record(4, 1'b1);

    // Random records over a spread of settings, extremes at the end
    for (int p = 0; p < 12; p++) begin
      if (p < 10) begin
        random_phase(sizes[p], slides[p], 35);
      end else begin
        configure(sizes[p], slides[p]);
        push_record(6, 1'b1);
        push_record(30, 1'b0);
      end
      set_idling(p % 4);
    end

    wait_for_drain();
    if (expected_rms.size() != 0) begin
      $error("%0d expected results never arrived", expected_rms.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/swrms_pkg.sv
design/swrms_ram.sv
design/swrms_rms_unit.sv
design/sliding_window_rms_power_top.sv
test/testbench.sv
